### src/bitmap_set_engine_core_assert.svh
// Assertion macros for the bitmap set engine.
`ifndef BITMAP_SET_ENGINE_CORE_ASSERT_SVH
`define BITMAP_SET_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BSET_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BSET_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### src/bset_pkg.sv
package bset_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [3:0] {
    K_INSERT  = 4'd0,
    K_REMOVE  = 4'd1,
    K_TEST    = 4'd2,
    K_COUNT   = 4'd3,
    K_NEXT    = 4'd4,
    K_AND     = 4'd5,
    K_OR      = 4'd6,
    K_ANDNOT  = 4'd7,
    K_COMPARE = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    WU_AND  = 2'd0,
    WU_OR   = 2'd1,
    WU_ANDN = 2'd2,
    WU_PASS = 2'd3
  } wu_op_e;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_LOOKUP = 6'b000100,
    ST_APPLY  = 6'b001000,
    ST_SCAN   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  // Word unit results.
  typedef struct packed {
    word_t            word;
    logic [5:0]       pop;
    logic [BIT_W-1:0] first_idx;
    logic             any;
    logic             a_not_b;
    logic             b_not_a;
    logic             overlap;
  } wu_res_t;

  // One result item.
  typedef struct packed {
    logic        is_member;
    logic        found;
    logic [9:0]  element_out;
    logic [10:0] member_count;
    word_t       result_word;
    logic        a_not_b;
    logic        b_not_a;
    logic        overlap;
    logic        out_of_range;
  } result_t;

endpackage

### src/bset_ram.sv
module bset_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/bset_word_unit.sv
module bset_word_unit (
  input  bset_pkg::word_t   a_i,
  input  bset_pkg::word_t   b_i,
  input  bset_pkg::wu_op_e  op_i,
  output bset_pkg::wu_res_t res_o
);

  bset_pkg::word_t w;
  bset_pkg::word_t p1;
  bset_pkg::word_t p2;
  bset_pkg::word_t p3;
  logic [7:0]      byte_sum;
  logic [bset_pkg::BIT_W-1:0] first;

  always_comb begin
    unique case (op_i)
      bset_pkg::WU_AND:  w = a_i & b_i;
      bset_pkg::WU_OR:   w = a_i | b_i;
      bset_pkg::WU_ANDN: w = a_i & ~b_i;
      bset_pkg::WU_PASS: w = a_i;
      default:           w = a_i;
    endcase
  end

  // Population count, pairwise then nibble then byte sums.
  assign p1 = w - ((w >> 1) & 32'h5555_5555);
  assign p2 = (p1 & 32'h3333_3333) + ((p1 >> 2) & 32'h3333_3333);
  assign p3 = (p2 + (p2 >> 4)) & 32'h0F0F_0F0F;
  assign byte_sum = p3[7:0] + p3[15:8] + p3[23:16] + p3[31:24];

  // Lowest set bit; zero when the word is empty.
  always_comb begin
    first = '0;
    for (int i = bset_pkg::WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        first = bset_pkg::BIT_W'(i);
      end
    end
  end

  always_comb begin
    res_o.word      = w;
    res_o.pop       = byte_sum[5:0];
    res_o.first_idx = first;
    res_o.any       = |w;
    res_o.a_not_b   = |(a_i & ~b_i);
    res_o.b_not_a   = |(b_i & ~a_i);
    res_o.overlap   = |(a_i & b_i);
  end

endmodule

### src/bitmap_set_engine_core.sv
// Bitmap set engine: holds a set of the integers 0 .. WORDS*32-1 as WORDS words of 32 bits in
// a single-port-read RAM and executes one operation per input item: insert, remove, test,
// population count, next member at or after an element, and word-wise AND, OR, AND-NOT and
// compare against a word of another set (flags a_not_b, b_not_a, overlap). Every item
// returns exactly one result item. After reset the engine sweeps the RAM to zero, one word
// per cycle, with in_stall_o high. Items are handled one at a time and in_stall_o is low
// only while the engine is idle; a finished result waits in the output register without
// blocking the next item. Insert, remove, test and the word operations, when in range, pass
// through RAM read, apply and write back, and hand-off, and the next item is taken once the
// sequencer is back in idle. Count and next member walk the bitmap one word per cycle
// through the RAM read port and the shared word unit (popcount, lowest-bit search, merge
// logic); next member starts at the word of its element and stops at the first hit.
`include "bitmap_set_engine_core_assert.svh"

module bitmap_set_engine_core #(
  parameter int unsigned WORDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  kind_i,
  input  logic [9:0]  element_i,
  input  logic [4:0]  word_index_i,
  input  logic [31:0] operand_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_member_o,
  output logic        found_o,
  output logic [9:0]  element_out_o,
  output logic [10:0] member_count_o,
  output logic [31:0] result_word_o,
  output logic        a_not_b_o,
  output logic        b_not_a_o,
  output logic        overlap_o,
  output logic        out_of_range_o
);

  localparam int unsigned AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CAPACITY = WORDS * bset_pkg::WORD_W;
  localparam logic [AW-1:0] LAST   = AW'(WORDS - 1);

  // Sequencer and item registers.
  bset_pkg::state_e  state_q, state_d;
  logic [3:0]        kind_q, kind_d;
  logic [9:0]        elem_q, elem_d;
  bset_pkg::word_t   opw_q, opw_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;
  logic              issue_q, issue_d;
  logic              pend_q, pend_d;
  logic              first_q, first_d;

  // Result under assembly and the output register.
  bset_pkg::result_t st_q, st_d;
  bset_pkg::result_t out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // RAM and word unit hookup.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  bset_pkg::word_t   ram_wdata;
  logic [AW-1:0]     ram_raddr;
  bset_pkg::word_t   ram_rdata;
  bset_pkg::wu_op_e  wu_op;
  bset_pkg::word_t   wu_b;
  bset_pkg::wu_res_t wu_res;

  bset_pkg::word_t   bit_mask;
  logic [11:0]       count_sum;

  bset_ram #(
    .WIDTH (bset_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bset_word_unit u_wu (
    .a_i   (ram_rdata),
    .b_i   (wu_b),
    .op_i  (wu_op),
    .res_o (wu_res)
  );

  assign bit_mask  = bset_pkg::word_t'(1) << elem_q[4:0];
  assign count_sum = {1'b0, st_q.member_count} + 12'(wu_res.pop);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    elem_d      = elem_q;
    opw_d       = opw_q;
    addr_d      = addr_q;
    pend_addr_d = pend_addr_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    first_d     = first_q;
    st_d        = st_q;
    out_d       = out_q;
    // Drop the held result once the consumer takes it.
    out_valid_d = out_valid_q && out_stall_i;

    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_raddr = addr_q;
    wu_op     = bset_pkg::WU_AND;
    wu_b      = '1;

    unique case (state_q)
      bset_pkg::ST_CLEAR: begin
        // Zero one word per cycle after reset.
        ram_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == LAST) begin
          state_d = bset_pkg::ST_IDLE;
        end
      end

      bset_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          elem_d  = element_i;
          opw_d   = operand_word_i;
          st_d    = '0;
          issue_d = 1'b1;
          pend_d  = 1'b0;
          first_d = 1'b1;
          case (kind_i) inside
            bset_pkg::K_INSERT, bset_pkg::K_REMOVE, bset_pkg::K_TEST: begin
              if (32'(element_i) < CAPACITY) begin
                addr_d  = AW'(element_i[9:5]);
                state_d = bset_pkg::ST_LOOKUP;
              end else begin
                // Insert beyond capacity is flagged; remove and test read as clear.
                st_d.out_of_range = (kind_i == bset_pkg::K_INSERT);
                state_d           = bset_pkg::ST_FINISH;
              end
            end
            bset_pkg::K_COUNT: begin
              addr_d  = '0;
              state_d = bset_pkg::ST_SCAN;
            end
            bset_pkg::K_NEXT: begin
              if (32'(element_i[9:5]) < WORDS) begin
                addr_d  = AW'(element_i[9:5]);
                state_d = bset_pkg::ST_SCAN;
              end else begin
                state_d = bset_pkg::ST_FINISH;
              end
            end
            bset_pkg::K_AND, bset_pkg::K_OR, bset_pkg::K_ANDNOT, bset_pkg::K_COMPARE: begin
              if (32'(word_index_i) < WORDS) begin
                addr_d  = AW'(word_index_i);
                state_d = bset_pkg::ST_LOOKUP;
              end else begin
                // Missing word reads as zero: only b_not_a can be set.
                st_d.out_of_range = 1'b1;
                st_d.b_not_a      = |operand_word_i;
                state_d           = bset_pkg::ST_FINISH;
              end
            end
            default: begin
              state_d = bset_pkg::ST_FINISH;
            end
          endcase
        end
      end

      bset_pkg::ST_LOOKUP: begin
        state_d = bset_pkg::ST_APPLY;
      end

      bset_pkg::ST_APPLY: begin
        case (kind_q) inside
          bset_pkg::K_INSERT: begin
            wu_op     = bset_pkg::WU_OR;
            wu_b      = bit_mask;
            ram_we    = 1'b1;
            ram_wdata = wu_res.word;
          end
          bset_pkg::K_REMOVE: begin
            wu_op     = bset_pkg::WU_ANDN;
            wu_b      = bit_mask;
            ram_we    = 1'b1;
            ram_wdata = wu_res.word;
          end
          bset_pkg::K_TEST: begin
            wu_op          = bset_pkg::WU_AND;
            wu_b           = bit_mask;
            st_d.is_member = wu_res.any;
          end
          bset_pkg::K_AND, bset_pkg::K_OR, bset_pkg::K_ANDNOT, bset_pkg::K_COMPARE: begin
            case (kind_q)
              bset_pkg::K_AND:    wu_op = bset_pkg::WU_AND;
              bset_pkg::K_OR:     wu_op = bset_pkg::WU_OR;
              bset_pkg::K_ANDNOT: wu_op = bset_pkg::WU_ANDN;
              default:            wu_op = bset_pkg::WU_PASS;
            endcase
            wu_b             = opw_q;
            ram_we           = 1'b1;
            ram_wdata        = wu_res.word;
            st_d.result_word = wu_res.word;
            st_d.a_not_b     = wu_res.a_not_b;
            st_d.b_not_a     = wu_res.b_not_a;
            st_d.overlap     = wu_res.overlap;
          end
          default: begin
          end
        endcase
        state_d = bset_pkg::ST_FINISH;
      end

      bset_pkg::ST_SCAN: begin
        // Issue one read per cycle and consume the word read the cycle before.
        if (first_q && (kind_q == bset_pkg::K_NEXT)) begin
          wu_b = bset_pkg::word_t'('1) << elem_q[4:0];
        end
        if (issue_q) begin
          addr_d      = addr_q + 1'b1;
          pend_addr_d = addr_q;
          issue_d     = (addr_q != LAST);
        end
        pend_d  = issue_q;
        first_d = first_q && !pend_q;
        if (pend_q) begin
          if (kind_q == bset_pkg::K_COUNT) begin
            st_d.member_count = count_sum[11] ? '1 : count_sum[10:0];
          end else if (wu_res.any) begin
            st_d.found       = 1'b1;
            st_d.element_out = 10'((32'(pend_addr_q) << bset_pkg::BIT_W)
                                   | 32'(wu_res.first_idx));
            state_d          = bset_pkg::ST_FINISH;
          end
        end
        if (!issue_q && !pend_q) begin
          state_d = bset_pkg::ST_FINISH;
        end
      end

      bset_pkg::ST_FINISH: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_d       = st_q;
          out_valid_d = 1'b1;
          state_d     = bset_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bset_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bset_pkg::ST_CLEAR;
      addr_q      <= '0;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    elem_q      <= elem_d;
    opw_q       <= opw_d;
    pend_addr_q <= pend_addr_d;
    st_q        <= st_d;
    out_q       <= out_d;
  end

  assign in_stall_o     = (state_q != bset_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign is_member_o    = out_q.is_member;
  assign found_o        = out_q.found;
  assign element_out_o  = out_q.element_out;
  assign member_count_o = out_q.member_count;
  assign result_word_o  = out_q.result_word;
  assign a_not_b_o      = out_q.a_not_b;
  assign b_not_a_o      = out_q.b_not_a;
  assign overlap_o      = out_q.overlap;
  assign out_of_range_o = out_q.out_of_range;

  // An accepted item always moves the sequencer out of idle.
  `BSET_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, state_q != bset_pkg::ST_IDLE, "item accepted but sequencer stayed idle")
  // The bitmap is written only by the clearing sweep or the apply step.
  `BSET_ASSERT_NOW(a_write_phase, ram_we, state_q == bset_pkg::ST_CLEAR || state_q == bset_pkg::ST_APPLY, "bitmap written outside clear or apply")
  // A new result appears only out of the hand-off state.
  `BSET_ASSERT_NOW(a_result_source, $rose(out_valid_q), $past(state_q == bset_pkg::ST_FINISH), "result raised without hand-off")

endmodule
